[hw/rtl/pcfc_pkg.sv]
// pcfc_pkg: shared types and constants of the rotating-led clock frame controller
// used by pcfc_divider, the top level and the checker; no dependencies

package pcfc_pkg;

	localparam int FRAMES_PER_TURN = 60;
	localparam int FRAME_IDX_W     = 6;
	localparam int TICK_W          = 16;
	localparam int SEC_W           = 17;
	localparam int NUM_W           = 20;
	localparam int PERIOD_W        = 16;
	localparam int BYTE_W          = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int DIV_CNT_W       = 5;

	localparam logic [SEC_W-1:0] SECONDS_PER_DAY = 17'd86400;
	localparam logic [NUM_W-1:0] SEC_PER_MIN     = 20'd60;
	localparam logic [NUM_W-1:0] SEC_PER_HOUR    = 20'd3600;

	localparam logic [FRAME_IDX_W-1:0] FRAME_LAST = FRAME_IDX_W'(FRAMES_PER_TURN - 1);

	localparam logic [TICK_W-1:0] TPS_RESET  = 16'd1625;
	localparam logic [NUM_W-1:0]  PNUM_RESET = 20'd761718;
	localparam logic [NUM_W-1:0]  CNUM_RESET = 20'd203125;

	localparam logic [BYTE_W-1:0] BYTE_ON   = 8'd255;
	localparam logic [BYTE_W-1:0] BYTE_BASE = 8'd128;
	localparam logic [BYTE_W-1:0] BYTE_OFF  = 8'd0;
	localparam logic [BYTE_W-1:0] CMP_MAX   = 8'd255;

	// event kinds
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_FRAME  = 2'd1;
	localparam logic [1:0] CMD_ROTATE = 2'd2;

	// result kinds
	localparam logic KIND_LEDS    = 1'b0;
	localparam logic KIND_COMPARE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TPS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PNUM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CNUM = 2'd2;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [NUM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hw/rtl/pov_clock_frame_controller_unit.sv]
// a tick or an unused command is taken while idle and gives no result; a frame slot
// or a rotation runs two divisions on the shared divider and then loads its result
// into the output register (a zero turn period runs no division, a zero target one)
// the next request is taken the cycle after the result loads, so a frame slot or rotation is
// finished before the next is taken; a result waiting in the output register stalls the sequencer
// reset: asynchronous; counters and seconds clear, frame index 59, compare 255, registers default
// top level: sequencer, clock state and output register; uses pcfc_pkg, pcfc_divider

module pov_clock_frame_controller_unit
	import pcfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // turn_period[15:0]
	input  logic [1:0]           s_tuser,   // command[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // first_byte[7:0], second_byte[15:8], compare_value[23:16]
	output logic                 m_tuser,   // result_kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NUM_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MIN  = 3'd1;
	localparam logic [2:0] ST_HR   = 3'd2;
	localparam logic [2:0] ST_TGT  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]             state_q;
	logic [TICK_W-1:0]      tps_q;
	logic [NUM_W-1:0]       pnum_q;
	logic [NUM_W-1:0]       cnum_q;
	logic [TICK_W-1:0]      tick_q;
	logic [SEC_W-1:0]       sec_q;
	logic [FRAME_IDX_W-1:0] frame_q;
	logic [BYTE_W-1:0]      fcmp_q;
	logic                   min_hit_q;
	logic                   pend_kind_q;
	logic [BYTE_W-1:0]      pend_first_q;
	logic [BYTE_W-1:0]      pend_second_q;
	logic [BYTE_W-1:0]      pend_cmp_q;
	logic                   m_tvalid_q;
	logic                   m_tuser_q;
	logic [23:0]            m_tdata_q;
	logic                   div_start_q;
	logic [NUM_W-1:0]       div_dividend_q;
	logic [NUM_W-1:0]       div_divisor_q;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	logic                   in_fire;
	logic                   out_load;
	logic                   div_start;
	logic [TICK_W-1:0]      tick_inc;
	logic [SEC_W-1:0]       sec_inc;
	logic                   idx_hit;
	logic [NUM_W-1:0]       q;

	pcfc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req   = {div_start_q, div_dividend_q, div_divisor_q};
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign tick_inc  = tick_q + 1'b1;
	assign sec_inc   = sec_q + 1'b1;
	assign q         = div_rsp.quotient;
	assign idx_hit   = (q == NUM_W'(frame_q));

	// a division starts on a frame slot, a nonzero period, the minute result or a nonzero target
	always_comb begin
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: div_start = in_fire && ((s_tuser == CMD_FRAME) ||
				(s_tuser == CMD_ROTATE && s_tdata != '0));
			ST_MIN:  div_start = div_rsp.done;
			ST_TGT:  div_start = div_rsp.done && (q != '0);
			default: div_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tps_q       <= TPS_RESET;
			pnum_q      <= PNUM_RESET;
			cnum_q      <= CNUM_RESET;
			tick_q      <= '0;
			sec_q       <= '0;
			frame_q     <= FRAME_LAST;
			fcmp_q      <= CMP_MAX;
			m_tvalid_q  <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= div_start;
			if (cfg_valid) begin
				case (cfg_index)
					REG_TPS:  tps_q  <= cfg_data[TICK_W-1:0];
					REG_PNUM: pnum_q <= cfg_data;
					REG_CNUM: cnum_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (s_tuser)
							CMD_TICK: begin
								if (tick_inc >= tps_q) begin
									tick_q <= '0;
									sec_q  <= (sec_inc >= SECONDS_PER_DAY) ? '0 : sec_inc;
								end else begin
									tick_q <= tick_inc;
								end
							end
							CMD_FRAME: begin
								state_q <= ST_MIN;
							end
							CMD_ROTATE: begin
								if (s_tdata == '0) begin
									fcmp_q  <= CMP_MAX;
									frame_q <= '0;
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_TGT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MIN: begin
					if (div_rsp.done) begin
						state_q <= ST_HR;
					end
				end
				ST_HR: begin
					if (div_rsp.done) begin
						frame_q <= (frame_q == '0) ? FRAME_LAST : frame_q - 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_TGT: begin
					if (div_rsp.done) begin
						// a zero target means the period exceeded the numerator
						if (q == '0) begin
							fcmp_q  <= CMP_MAX;
							frame_q <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (div_rsp.done) begin
						if (q >= NUM_W'(2) && q <= NUM_W'(256)) begin
							fcmp_q <= BYTE_W'(q - 1'b1);
						end else begin
							fcmp_q <= CMP_MAX;
						end
						frame_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload side: divider operands, pending result and output register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (s_tuser == CMD_FRAME) begin
						div_dividend_q <= NUM_W'(sec_q);
						div_divisor_q  <= SEC_PER_MIN;
					end else begin
						div_dividend_q <= pnum_q;
						div_divisor_q  <= NUM_W'(s_tdata);
					end
					pend_kind_q   <= (s_tuser == CMD_FRAME) ? KIND_LEDS : KIND_COMPARE;
					pend_first_q  <= BYTE_OFF;
					pend_second_q <= BYTE_OFF;
				end
			end
			ST_MIN: begin
				if (div_rsp.done) begin
					min_hit_q      <= idx_hit;
					div_dividend_q <= NUM_W'(sec_q);
					div_divisor_q  <= SEC_PER_HOUR;
				end
			end
			ST_HR: begin
				if (div_rsp.done) begin
					pend_cmp_q <= fcmp_q;
					if (min_hit_q) begin
						pend_first_q  <= BYTE_ON;
						pend_second_q <= BYTE_ON;
					end else begin
						pend_first_q  <= BYTE_BASE;
						pend_second_q <= idx_hit ? BYTE_ON : BYTE_OFF;
					end
				end
			end
			ST_TGT: begin
				if (div_rsp.done) begin
					div_dividend_q <= cnum_q;
					div_divisor_q  <= q;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					m_tuser_q <= pend_kind_q;
					// a rotation result carries the freshly written compare value
					m_tdata_q <= {(pend_kind_q == KIND_COMPARE) ? fcmp_q : pend_cmp_q,
						pend_second_q, pend_first_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hw/rtl/pcfc_divider.sv]
// pcfc_divider: restoring divider, one quotient bit per cycle, shared by all divisions
// depends on pcfc_pkg

module pcfc_divider
	import pcfc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [NUM_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [NUM_W:0]       trial;
	logic [NUM_W:0]       diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			// keep the difference when the subtraction does not borrow, else the trial remainder
			if (!diff[NUM_W]) begin
				rem_q <= diff[NUM_W-1:0];
			end else begin
				rem_q <= trial[NUM_W-1:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], ~diff[NUM_W]};
		end
	end

	assign rsp = {done_q, quo_q};

endmodule

[hw/rtl/pcfc_checker.sv]
// pcfc_checker: port-level assertions for pov_clock_frame_controller_unit, bound to it below
// depends on pcfc_pkg

module pcfc_checker
	import pcfc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	// a frame request occupies the divider, so no request follows in the next cycle
	a_busy_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_FRAME |=> !s_tready)
		else $error("request accepted while a frame slot is in work");

	a_compare_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:16] != 8'd0)
		else $error("compare value of zero");

	a_compare_kind_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_COMPARE |-> m_tdata[15:0] == 16'd0)
		else $error("compare result with nonzero led bytes");

	a_led_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_LEDS |->
			(m_tdata[15:0] == 16'hFFFF) || (m_tdata[15:0] == 16'hFF80)
			|| (m_tdata[15:0] == 16'h0080))
		else $error("led byte pair not one of the three patterns");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind pov_clock_frame_controller_unit pcfc_checker u_pcfc_checker (.*);

[bench/pov_clock_frame_controller_unit_tb.sv]
// testbench for pov_clock_frame_controller_unit: drives ticks, frame slots and rotations,
// predicts every led byte pair and compare value, and checks results in order
// depends on pcfc_pkg and the top level rtl only

module pov_clock_frame_controller_unit_tb;
	import pcfc_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         HOLD_CYCLES = 400;
	localparam int         SETTLE      = 64;
	localparam int         CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
		logic [BYTE_W-1:0] cmp;
	} frame_result_t;

	class frame_byte_tracker;
		logic [TICK_W-1:0]      ticks_per_second;
		logic [NUM_W-1:0]       period_numerator;
		logic [NUM_W-1:0]       compare_numerator;
		logic [TICK_W-1:0]      tick_count;
		logic [SEC_W-1:0]       seconds;
		logic [FRAME_IDX_W-1:0] frame_index;
		logic [BYTE_W-1:0]      frame_compare;
		frame_result_t          pending_results[$];
		int                     error_count;

		function new();
			ticks_per_second  = TPS_RESET;
			period_numerator  = PNUM_RESET;
			compare_numerator = CNUM_RESET;
			tick_count        = '0;
			seconds           = '0;
			frame_index       = FRAME_LAST;
			frame_compare     = CMP_MAX;
			error_count       = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] value);
			case (idx)
			REG_TPS:  ticks_per_second  = value[TICK_W-1:0];
			REG_PNUM: period_numerator  = value;
			REG_CNUM: compare_numerator = value;
			default: ;
			endcase
		endfunction

		function logic [BYTE_W-1:0] compare_for_period(logic [PERIOD_W-1:0] period);
			logic [NUM_W-1:0] target;
			logic [NUM_W-1:0] quotient;
			if (period == '0)
				return CMP_MAX;
			target = period_numerator / NUM_W'(period);
			if (target == '0)
				return CMP_MAX;
			quotient = compare_numerator / target;
			if (quotient >= 2 && quotient <= 256)
				return BYTE_W'(quotient - 1'b1);
			return CMP_MAX;
		endfunction

		function void note_request(logic [1:0] command, logic [PERIOD_W-1:0] period);
			frame_result_t r;
			case (command)
			CMD_TICK: begin
				tick_count = tick_count + 1'b1;
				if (tick_count >= ticks_per_second) begin
					tick_count = '0;
					seconds = (seconds + 1'b1 >= SECONDS_PER_DAY) ? '0 : seconds + 1'b1;
				end
			end
			CMD_FRAME: begin
				r.kind   = KIND_LEDS;
				r.first  = BYTE_BASE;
				r.second = BYTE_OFF;
				r.cmp    = frame_compare;
				// minute hand wins over hour hand
				if (seconds / SEC_PER_MIN == NUM_W'(frame_index)) begin
					r.first  = BYTE_ON;
					r.second = BYTE_ON;
				end else if (seconds / SEC_PER_HOUR == NUM_W'(frame_index)) begin
					r.second = BYTE_ON;
				end
				frame_index = (frame_index == '0) ? FRAME_LAST : frame_index - 1'b1;
				pending_results.push_back(r);
			end
			CMD_ROTATE: begin
				frame_index   = '0;
				frame_compare = compare_for_period(period);
				r.kind   = KIND_COMPARE;
				r.first  = BYTE_OFF;
				r.second = BYTE_OFF;
				r.cmp    = frame_compare;
				pending_results.push_back(r);
			end
			default: ;
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void check_result(logic kind, logic [23:0] data);
			frame_result_t want;
			frame_result_t got;
			got.kind   = kind;
			got.first  = data[7:0];
			got.second = data[15:8];
			got.cmp    = data[23:16];
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: kind %0d bytes %0d/%0d compare %0d",
						got.kind, got.first, got.second, got.cmp);
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind || got.first !== want.first ||
					got.second !== want.second || got.cmp !== want.cmp) begin
				error_count++;
				if (error_count <= 10)
					$display("result mismatch: expected kind %0d bytes %0d/%0d compare %0d, %s%0d %s%0d/%0d %s%0d",
						want.kind, want.first, want.second, want.cmp,
						"got kind ", got.kind, "bytes ", got.first, got.second,
						"compare ", got.cmp);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // turn_period[15:0]
	logic [1:0]           s_tuser;   // command[1:0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;   // first_byte[7:0], second_byte[15:8], compare_value[23:16]
	logic                 m_tuser;   // result_kind
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NUM_W-1:0]     cfg_data;

	frame_byte_tracker tracker;
	bit                calm_tail;
	bit                hold_req;
	bit                sender_idling;
	int                cycle_count = 0;

	pov_clock_frame_controller_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
			tracker.check_result(m_tuser, m_tdata);
	end

	// result side: short random stalls, plus one long hold-off on request
	initial begin : rx_side
		int stall_left;
		int hold_left;
		bit idling_on;
		stall_left = 0;
		hold_left  = 0;
		idling_on  = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if ($urandom_range(0, 99) == 0)
				idling_on = !idling_on;
			if (hold_left == 0 && stall_left == 0 && idling_on && !calm_tail &&
					$urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 4);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task send_request(input logic [1:0] cmd, input logic [PERIOD_W-1:0] period);
		if ($urandom_range(0, 63) == 0)
			sender_idling = !sender_idling;
		if (sender_idling && !calm_tail && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= period;
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.note_request(cmd, period);
	endtask

	task send_ticks(input int count);
		repeat (count) send_request(CMD_TICK, 16'($urandom));
	endtask

	function logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 5))
		0:       return '0;
		1:       return '1;
		2:       return PERIOD_W'($urandom_range(1, 1500));
		3:       return PERIOD_W'($urandom_range(1, 64));
		default: return PERIOD_W'($urandom);
		endcase
	endfunction

	// a rotation, if asked for, followed by frame slots, ticks sprinkled in between
	task send_turn(input logic [PERIOD_W-1:0] period, input int frames, input bit rotate);
		if (rotate)
			send_request(CMD_ROTATE, period);
		repeat (frames) begin
			if ($urandom_range(0, 3) == 0)
				send_ticks($urandom_range(1, 3));
			send_request(CMD_FRAME, 16'($urandom));
		end
	endtask

	task drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task settle();
		drain_results();
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NUM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		tracker.write_register(idx, value);
	endtask

	task configure(input logic [NUM_W-1:0] tps, input logic [NUM_W-1:0] pnum,
			input logic [NUM_W-1:0] cnum);
		write_reg(REG_TPS, tps);
		write_reg(REG_PNUM, pnum);
		write_reg(REG_CNUM, cnum);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task run_random(input int target_items);
		int count;
		int len;
		logic [1:0] cmd;
		count = 0;
		while (count < target_items) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				len = $urandom_range(1, 60);
				// now and then a turn with no rotation in front of it
				send_turn(pick_period(), len, $urandom_range(0, 9) != 0);
				count += len + 1;
			end
			4, 5: begin
				len = $urandom_range(1, 20);
				send_ticks(len);
				count += len;
			end
			6: begin
				if ($urandom_range(0, 3) == 0)
					drain_results();
			end
			default: begin
				cmd = 2'($urandom_range(0, 3));
				send_request(cmd, 16'($urandom));
				if (cmd != CMD_UNUSED)
					count++;
			end
			endcase
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_TICK;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TPS;
		cfg_data  = '0;
		calm_tail = 1'b0;
		hold_req  = 1'b0;
		sender_idling = 1'b1;
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: background, zero period, minute hand at frame 0
		send_request(CMD_FRAME, 16'h0000);
		send_request(CMD_ROTATE, 16'h0000);
		send_request(CMD_FRAME, 16'hFFFF);
		send_request(CMD_FRAME, 16'h0000);
		send_request(CMD_ROTATE, 16'hFFFF);
		send_request(CMD_ROTATE, 16'd500);
		send_request(CMD_ROTATE, 16'd1);
		send_request(CMD_TICK, 16'hFFFF);
		send_request(CMD_UNUSED, 16'hAAAA);
		send_request(CMD_TICK, 16'h5555);
		send_request(CMD_FRAME, 16'h0000);
		settle();

		// zero prescale, hour hand alone, quotient of 256, zero target
		configure(20'd0, 20'd1000, 20'd256);
		send_ticks(61);
		send_request(CMD_ROTATE, 16'd1000);
		send_request(CMD_FRAME, 16'h1234);
		send_request(CMD_ROTATE, 16'd400);
		send_request(CMD_ROTATE, 16'd2000);
		send_request(CMD_FRAME, 16'h0000);
		settle();

		// smallest valid compare, quotient of one
		configure(20'd0, 20'd1000, 20'd2);
		send_request(CMD_ROTATE, 16'd1000);
		send_request(CMD_ROTATE, 16'd500);
		send_request(CMD_FRAME, 16'h0000);
		settle();

		// zero prescale: seconds run on through a few minutes, turns spread between them
		configure(20'd0, PNUM_RESET, CNUM_RESET);
		repeat (3) begin
			send_ticks(30);
			send_turn(pick_period(), $urandom_range(20, 40), 1'b1);
		end
		settle();

		// largest numerators; long output hold-off, then sender waits it out
		configure(20'd1, 20'hFFFFF, 20'hFFFFF);
		hold_req = 1'b1;
		send_turn(16'd7, 40, 1'b1);
		drain_results();
		run_random(150);
		settle();

		configure(20'd65535, 20'd1, 20'd1);
		run_random(100);
		settle();

		// upper bits of the prescale write are not part of the register
		configure({4'($urandom), 16'($urandom_range(2, 6))},
			NUM_W'($urandom_range(1000, 1048575)), NUM_W'($urandom_range(256, 200000)));
		run_random(150);
		settle();

		calm_tail = 1'b1;
		configure(NUM_W'(TPS_RESET), PNUM_RESET, CNUM_RESET);
		run_random(120);
		settle();

		if (tracker.error_count == 0 && tracker.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[pov_clock_frame_controller_unit.f]
hw/rtl/pcfc_pkg.sv
hw/rtl/pcfc_divider.sv
hw/rtl/pov_clock_frame_controller_unit.sv
hw/rtl/pcfc_checker.sv
bench/pov_clock_frame_controller_unit_tb.sv
